FILE: sv/poc_pkg.sv
// ----------------------------------------------------------------------------
// poc_pkg
// Shared constants for the pupil offset clamp block.
// ----------------------------------------------------------------------------
package poc_pkg;

   // Width of every result offset, two's complement
   localparam int OUT_BITS = 12;

   // Configuration port
   localparam int CSR_IDX_BITS = 4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_X = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_Y = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_W = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_H = 4'd3;

   // Eye geometry
   localparam int RADIUS_SUB = 4;   // taken off the raw radius
   localparam int RADIUS_MIN = 8;   // radius floor
   localparam int LIMIT_SUB  = 3;   // taken off r - r/3

endpackage

FILE: sv/poc_queue.sv
// ----------------------------------------------------------------------------
// poc_queue
// Two-entry FIFO between the classifier and the clamp engine.
// ----------------------------------------------------------------------------
module poc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/poc_front.sv
// ----------------------------------------------------------------------------
// poc_front
// Accepts a pointer item, forms both eye vectors and the clamp limit, and
// flags which eyes need the clamp before handing the job to the queue.
// ----------------------------------------------------------------------------
module poc_front import poc_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] pointer_x,
   input  logic [COORD_BITS-1:0] pointer_y,
   input  logic [COORD_BITS-1:0] window_x,
   input  logic [COORD_BITS-1:0] window_y,
   input  logic [COORD_BITS-1:0] window_w,
   input  logic [COORD_BITS-1:0] window_h,
   output logic                  job_valid,
   input  logic                  job_ready,
   output logic [2+(COORD_BITS-1)+3*(COORD_BITS+2)+2*(2*COORD_BITS+3)-1:0] job_data
);

   localparam int DW    = COORD_BITS + 2;
   localparam int LW    = COORD_BITS - 1;
   localparam int SQW   = 2 * COORD_BITS + 2;
   localparam int D2W   = 2 * COORD_BITS + 3;
   localparam int SHIFT = COORD_BITS + 1;
   localparam logic [COORD_BITS-1:0] RECIP =
      COORD_BITS'(((1 << (COORD_BITS + 1)) + 2) / 3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_PUSH
   } state_type;

   state_type              state_ff;
   logic signed [DW-1:0]   dx0_ff, dx1_ff, dy_ff;
   logic [LW-1:0]          r_ff;
   logic [LW-1:0]          lim_ff;
   logic [SQW-1:0]         sqx0_ff, sqx1_ff, sqy_ff;
   logic [D2W-1:0]         d2_0_ff, d2_1_ff;
   logic [2*LW-1:0]        limsq_ff;

   logic [LW-1:0]          q, half, m, r_in;
   logic [DW-1:0]          w3, cx0, cx1, cy;
   logic [DW-1:0]          dx0_in, dx1_in, dy_in;
   logic [LW+COORD_BITS-1:0] r_prod;
   logic [LW-1:0]          r_third;
   logic signed [2*DW-1:0] sqx0_full, sqx1_full, sqy_full;
   logic [2*LW-1:0]        limsq_in;
   logic                   clamp0, clamp1;

   // Eye geometry from the window rectangle
   always_comb begin
      q    = LW'(window_w >> 2);
      half = LW'(window_h >> 1);
      m    = (q < half) ? q : half;
      r_in = (m < LW'(RADIUS_MIN + RADIUS_SUB)) ? LW'(RADIUS_MIN) : m - LW'(RADIUS_SUB);
      w3   = DW'({window_w, 1'b0}) + DW'(window_w);
      cx0  = DW'(window_x) + DW'(q) + DW'(1);
      cx1  = DW'(window_x) + (w3 >> 2) - DW'(1);
      cy   = DW'(window_y) + DW'(half);
      dx0_in = DW'(pointer_x) - cx0;
      dx1_in = DW'(pointer_x) - cx1;
      dy_in  = DW'(pointer_y) - cy;
   end

   // r/3 by reciprocal multiply, exact for r below 2^(COORD_BITS-1)
   assign r_prod  = (LW+COORD_BITS)'(r_ff) * (LW+COORD_BITS)'(RECIP);
   assign r_third = LW'(r_prod >> SHIFT);

   assign sqx0_full = dx0_ff * dx0_ff;
   assign sqx1_full = dx1_ff * dx1_ff;
   assign sqy_full  = dy_ff * dy_ff;
   assign limsq_in  = lim_ff * lim_ff;

   assign clamp0 = (d2_0_ff > D2W'(limsq_ff));
   assign clamp1 = (d2_1_ff > D2W'(limsq_ff));

   assign in_ready  = (state_ff == ST_IDLE);
   assign job_valid = (state_ff == ST_PUSH);
   assign job_data  = {clamp1, clamp0, lim_ff, dy_ff, dx1_ff, dx0_ff, d2_1_ff, d2_0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  dx0_ff   <= dx0_in;
                  dx1_ff   <= dx1_in;
                  dy_ff    <= dy_in;
                  r_ff     <= r_in;
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               lim_ff   <= r_ff - r_third - LW'(LIMIT_SUB);
               sqx0_ff  <= SQW'(sqx0_full);
               sqx1_ff  <= SQW'(sqx1_full);
               sqy_ff   <= SQW'(sqy_full);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               d2_0_ff  <= D2W'(sqx0_ff) + D2W'(sqy_ff);
               d2_1_ff  <= D2W'(sqx1_ff) + D2W'(sqy_ff);
               limsq_ff <= limsq_in;
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (job_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/poc_back.sv
// ----------------------------------------------------------------------------
// poc_back
// Clamp engine: bit-serial square root and two-lane restoring division per
// clamped eye, then the moved flag, stored offsets and result register.
// ----------------------------------------------------------------------------
module poc_back import poc_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   output logic                       job_ready,
   input  logic [2+(COORD_BITS-1)+3*(COORD_BITS+2)+2*(2*COORD_BITS+3)-1:0] job_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_left_off_x,
   output logic signed [OUT_BITS-1:0] rsp_left_off_y,
   output logic signed [OUT_BITS-1:0] rsp_right_off_x,
   output logic signed [OUT_BITS-1:0] rsp_right_off_y,
   output logic                       rsp_moved
);

   localparam int DW    = COORD_BITS + 2;
   localparam int LW    = COORD_BITS - 1;
   localparam int D2W   = 2 * COORD_BITS + 3;
   localparam int RW    = COORD_BITS + 2;
   localparam int PW    = DW + LW;
   localparam int JW    = 2 + LW + 3 * DW + 2 * D2W;
   localparam int CNT_W = $clog2(PW + 1);
   localparam int B_DX  = 2 * D2W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EYE,
      ST_ROOT,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic                 eye_ff;
   logic [JW-1:0]        job_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [2*RW-1:0]      rad_ff;
   logic [RW+1:0]        rem_ff;
   logic [RW-1:0]        root_ff;
   logic [PW-1:0]        num_x_ff, num_y_ff;
   logic [RW-1:0]        dr_x_ff, dr_y_ff;
   logic                 neg_x_ff, neg_y_ff;
   logic signed [DW-1:0] lx_ff, ly_ff, rx_ff, ry_ff;
   logic signed [DW-1:0] st_lx_ff, st_ly_ff, st_rx_ff, st_ry_ff;
   logic                 rsp_valid_ff;
   logic signed [OUT_BITS-1:0] out_lx_ff, out_ly_ff, out_rx_ff, out_ry_ff;
   logic                 moved_ff;

   logic [D2W-1:0]       d2_0, d2_1, cur_d2;
   logic signed [DW-1:0] dx0, dx1, dy, cur_dx;
   logic [LW-1:0]        lim;
   logic                 clamp0, clamp1, cur_clamp;
   logic [RW+3:0]        rem_sh, trial;
   logic                 root_ge;
   logic [DW-1:0]        mag_x, mag_y;
   logic [RW:0]          sh_x, sh_y;
   logic                 ge_x, ge_y;
   logic signed [DW-1:0] q_x, q_y, res_x, res_y;
   logic                 load_rsp;
   logic                 moved_in;

   // Unpack the held job
   assign d2_0   = job_ff[0 +: D2W];
   assign d2_1   = job_ff[D2W +: D2W];
   assign dx0    = job_ff[B_DX +: DW];
   assign dx1    = job_ff[B_DX + DW +: DW];
   assign dy     = job_ff[B_DX + 2*DW +: DW];
   assign lim    = job_ff[B_DX + 3*DW +: LW];
   assign clamp0 = job_ff[B_DX + 3*DW + LW];
   assign clamp1 = job_ff[B_DX + 3*DW + LW + 1];

   assign cur_d2    = eye_ff ? d2_1 : d2_0;
   assign cur_dx    = eye_ff ? dx1 : dx0;
   assign cur_clamp = eye_ff ? clamp1 : clamp0;

   // One root bit per cycle
   assign rem_sh  = {rem_ff, rad_ff[2*RW-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);

   // Magnitudes for the multiply
   assign mag_x = cur_dx[DW-1] ? DW'(-cur_dx) : DW'(cur_dx);
   assign mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);

   // One quotient bit per cycle in each lane
   assign sh_x = {dr_x_ff, num_x_ff[PW-1]};
   assign sh_y = {dr_y_ff, num_y_ff[PW-1]};
   assign ge_x = (sh_x >= {1'b0, root_ff});
   assign ge_y = (sh_y >= {1'b0, root_ff});

   // Quotient after the last step, with the sign put back
   assign q_x   = DW'({num_x_ff[PW-2:0], ge_x});
   assign q_y   = DW'({num_y_ff[PW-2:0], ge_y});
   assign res_x = neg_x_ff ? -q_x : q_x;
   assign res_y = neg_y_ff ? -q_y : q_y;

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign moved_in = (lx_ff != st_lx_ff) || (ly_ff != st_ly_ff) ||
                     (rx_ff != st_rx_ff) || (ry_ff != st_ry_ff);

   assign job_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_off_x  = out_lx_ff;
   assign rsp_left_off_y  = out_ly_ff;
   assign rsp_right_off_x = out_rx_ff;
   assign rsp_right_off_y = out_ry_ff;
   assign rsp_moved       = moved_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eye_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_lx_ff     <= '0;
         st_ly_ff     <= '0;
         st_rx_ff     <= '0;
         st_ry_ff     <= '0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  eye_ff   <= 1'b0;
                  state_ff <= ST_EYE;
               end
            end
            ST_EYE: begin
               if (cur_clamp) begin
                  rad_ff   <= (2*RW)'(cur_d2);
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= CNT_W'(RW - 1);
                  state_ff <= ST_ROOT;
               end else begin
                  if (eye_ff) begin
                     rx_ff <= cur_dx;
                     ry_ff <= dy;
                     state_ff <= ST_DONE;
                  end else begin
                     lx_ff  <= cur_dx;
                     ly_ff  <= dy;
                     eye_ff <= 1'b1;
                  end
               end
            end
            ST_ROOT: begin
               rad_ff  <= {rad_ff[2*RW-3:0], 2'b00};
               rem_ff  <= root_ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
               root_ff <= {root_ff[RW-2:0], root_ge};
               cnt_ff  <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               num_x_ff <= PW'(mag_x) * PW'(lim);
               num_y_ff <= PW'(mag_y) * PW'(lim);
               neg_x_ff <= cur_dx[DW-1];
               neg_y_ff <= dy[DW-1];
               dr_x_ff  <= '0;
               dr_y_ff  <= '0;
               cnt_ff   <= CNT_W'(PW - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               dr_x_ff  <= ge_x ? RW'(sh_x - {1'b0, root_ff}) : RW'(sh_x);
               dr_y_ff  <= ge_y ? RW'(sh_y - {1'b0, root_ff}) : RW'(sh_y);
               num_x_ff <= {num_x_ff[PW-2:0], ge_x};
               num_y_ff <= {num_y_ff[PW-2:0], ge_y};
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  if (eye_ff) begin
                     rx_ff    <= res_x;
                     ry_ff    <= res_y;
                     state_ff <= ST_DONE;
                  end else begin
                     lx_ff    <= res_x;
                     ly_ff    <= res_y;
                     eye_ff   <= 1'b1;
                     state_ff <= ST_EYE;
                  end
               end
            end
            ST_DONE: begin
               if (load_rsp) begin
                  st_lx_ff     <= lx_ff;
                  st_ly_ff     <= ly_ff;
                  st_rx_ff     <= rx_ff;
                  st_ry_ff     <= ry_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         out_lx_ff <= OUT_BITS'(lx_ff);
         out_ly_ff <= OUT_BITS'(ly_ff);
         out_rx_ff <= OUT_BITS'(rx_ff);
         out_ry_ff <= OUT_BITS'(ry_ff);
         moved_ff  <= moved_in;
      end
   end

   a_root_only_when_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> cur_clamp)
      else $error("root search on an eye that needs no clamp");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (root_ff != '0))
      else $error("zero divisor after root search");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item did not reach the result register");

endmodule

FILE: sv/pupil_offset_clamp_core.sv
// ----------------------------------------------------------------------------
// pupil_offset_clamp_core
// Pupil offsets for two eyes that follow a pointer inside a window.
// ----------------------------------------------------------------------------
// Each pointer item yields one result: the left and right pupil offsets from
// their eye centers and a moved flag that is set when any offset differs from
// the previous result (all offsets start at zero after reset). The window
// rectangle is set through the csr_ port and must only change while the block
// is idle. The front classifier steps each item through accept, square, sum
// and hand-off, the last of which waits while the queue is full, and then
// accepts the next item while the clamp engine works, with a two-entry queue
// between them. The clamp engine passes an unclamped eye straight through, and
// per clamped eye runs a bit-serial square root of COORD_BITS+2 steps, then a
// multiply by the clamp limit and a restoring division of 2*COORD_BITS+1 steps
// for both components in parallel. The result sits in an output register, so
// the engine starts the next queued item as soon as its result has moved into
// that register; a finished item waits only while the previous result is
// still untaken.
// ----------------------------------------------------------------------------
module pupil_offset_clamp_core import poc_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [COORD_BITS-1:0]      req_pointer_x,
   input  logic [COORD_BITS-1:0]      req_pointer_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_left_off_x,
   output logic signed [OUT_BITS-1:0] rsp_left_off_y,
   output logic signed [OUT_BITS-1:0] rsp_right_off_x,
   output logic signed [OUT_BITS-1:0] rsp_right_off_y,
   output logic                       rsp_moved,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]      csr_wdata
);

   localparam int JW = 2 + (COORD_BITS - 1) + 3 * (COORD_BITS + 2) + 2 * (2 * COORD_BITS + 3);

   logic [COORD_BITS-1:0] window_x_ff, window_y_ff, window_w_ff, window_h_ff;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   logic [JW-1:0]         push_data, pop_data;

   // Window registers; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_x_ff <= '0;
         window_y_ff <= '0;
         window_w_ff <= '0;
         window_h_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_X: window_x_ff <= csr_wdata;
            CSR_WINDOW_Y: window_y_ff <= csr_wdata;
            CSR_WINDOW_W: window_w_ff <= csr_wdata;
            CSR_WINDOW_H: window_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accept and classify each item
   poc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pointer_x (req_pointer_x),
      .pointer_y (req_pointer_y),
      .window_x  (window_x_ff),
      .window_y  (window_y_ff),
      .window_w  (window_w_ff),
      .window_h  (window_h_ff),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_data  (push_data)
   );

   // Hold up to two classified items
   poc_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Clamp, compare with the stored offsets, and present the result
   poc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (pop_valid),
      .job_ready       (pop_ready),
      .job_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_off_x  (rsp_left_off_x),
      .rsp_left_off_y  (rsp_left_off_y),
      .rsp_right_off_x (rsp_right_off_x),
      .rsp_right_off_y (rsp_right_off_y),
      .rsp_moved       (rsp_moved)
   );

endmodule
